// File: rtl/fpq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpq_pkg: shared types and constants of the frame pacing queue
// Command codes, register indexes, field widths and the control and status
// bundles that run between the controller and the datapath.
// ---------------------------------------------------------------------------
package fpq_pkg;

   // field widths fixed by the item format
   localparam int TIME_W   = 64;
   localparam int PERIOD_W = 30;
   localparam int OSEQ_W   = 32;
   localparam int QFILL_W  = 3;
   localparam int CSR_IDX_W = 1;

   // item commands
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PACE_ENABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_NS   = 1'b1;

   // period after reset: one sixtieth of a second
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 30'd16666667;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV
   } fpq_state_type;

   // controller to datapath
   typedef struct packed {
      logic take;       // capture the request item
      logic exec;       // update queue state and load the result register
      logic div_start;  // start the deadline remainder
      logic fin;        // write the caught-up deadline
   } fpq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;   // result register free by the next edge
      logic need_div;   // held item needs a deadline catch-up
      logic div_done;   // remainder is final
   } fpq_sts_type;

endpackage
`default_nettype wire

// File: rtl/fpq_rem_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpq_rem_unit: bit-serial remainder
// Restoring division of a 64-bit time span by the period, one dividend bit
// per cycle; only the remainder is kept.
// ---------------------------------------------------------------------------
module fpq_rem_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [fpq_pkg::TIME_W-1:0]    dividend,
   input  wire logic [fpq_pkg::PERIOD_W-1:0]  divisor,
   output logic                               done,
   output logic [fpq_pkg::PERIOD_W-1:0]       remainder
);
   import fpq_pkg::*;

   localparam int CNT_W = $clog2(TIME_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [TIME_W-1:0]    dvd_ff, dvd_in;
   logic [PERIOD_W-1:0]  div_ff, div_in;
   logic [PERIOD_W-1:0]  rem_ff, rem_in;
   logic [PERIOD_W:0]    trial;
   logic [PERIOD_W:0]    trial_sub;
   logic                 trial_ge;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial     = {rem_ff, dvd_ff[TIME_W-1]};
      trial_ge  = trial >= {1'b0, div_ff};
      trial_sub = trial - {1'b0, div_ff};
   end

   // sequence the steps
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_LAST;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = trial_ge ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         dvd_in = {dvd_ff[TIME_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   // a zero divisor never reaches the unit
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      start |-> divisor != '0)
      else $error("remainder started with a zero divisor");

   // the result pulse follows the step run, never a fresh start
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("remainder done without a preceding step run");

   // the remainder stays below the divisor once final
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < div_ff)
      else $error("remainder not below divisor");

endmodule
`default_nettype wire

// File: rtl/fpq_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpq_ctrl: item sequencer
// Takes one item, executes it once the result register is free and waits
// for the deadline remainder when the item needs a catch-up.
// ---------------------------------------------------------------------------
module fpq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire fpq_pkg::fpq_sts_type sts,
   output fpq_pkg::fpq_cmd_type      cmd
);
   import fpq_pkg::*;

   fpq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            // hold off transfers while reset is applied
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.take = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.out_free) begin
               cmd.exec = 1'b1;
               if (sts.need_div) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a catch-up start always leads into the remainder wait
   a_start_to_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> state_ff == ST_DIV)
      else $error("remainder start without entering the wait state");

   // execution never overwrites a result that is still held
   a_exec_free: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> sts.out_free)
      else $error("item executed while the result register was busy");

   // a finished catch-up returns to taking items
   a_fin_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> state_ff == ST_IDLE)
      else $error("deadline write did not return to idle");

endmodule
`default_nettype wire

// File: rtl/fpq_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpq_datapath: queue state, deadline and result register
// Holds the sequence ring, its pointers and fill count, the pacing deadline,
// the registers and the held item, and builds each result.
// ---------------------------------------------------------------------------
module fpq_datapath #(
   parameter int RING_DEPTH = 4,
   parameter int SEQ_BITS   = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire fpq_pkg::fpq_cmd_type              cmd,
   output fpq_pkg::fpq_sts_type                   sts,
   input  wire logic                              csr_write_en,
   input  wire logic [fpq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fpq_pkg::PERIOD_W-1:0]      csr_wdata,
   input  wire logic                              req_command,
   input  wire logic [fpq_pkg::OSEQ_W-1:0]        req_frame_num,
   input  wire logic [fpq_pkg::TIME_W-1:0]        req_now_ns,
   input  wire logic                              req_sink_open,
   input  wire logic                              req_write_ok,
   input  wire logic [fpq_pkg::TIME_W-1:0]        req_done_ns,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_emitted,
   output logic [fpq_pkg::OSEQ_W-1:0]             rsp_emitted_seq,
   output logic                                   rsp_write_failed,
   output logic                                   rsp_repeat_of_last,
   output logic                                   rsp_waiting_empty,
   output logic                                   rsp_dropped_oldest,
   output logic [fpq_pkg::QFILL_W-1:0]            rsp_queue_fill
);
   import fpq_pkg::*;

   localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RING_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);

   // registers
   logic                 pace_ff;
   logic [PERIOD_W-1:0]  period_ff;
   logic [PERIOD_W-1:0]  period_eff;

   // held item
   logic                 item_cmd_ff;
   logic [SEQ_BITS-1:0]  item_seq_ff;
   logic [TIME_W-1:0]    item_now_ff;
   logic                 item_sink_ff;
   logic                 item_wok_ff;
   logic [TIME_W-1:0]    item_done_ff;
   logic [SEQ_BITS+OSEQ_W-1:0] seq_wide;

   // queue state
   logic [SEQ_BITS-1:0]  ring_ff [RING_DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in;
   logic [PTR_W-1:0]     rd_ff, rd_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [TIME_W-1:0]    deadline_ff, deadline_in;
   logic                 shown_ff, shown_in;
   logic [SEQ_BITS-1:0]  last_ff, last_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 emitted_ff, emitted_in;
   logic [OSEQ_W-1:0]    eseq_ff, eseq_in;
   logic                 wfail_ff, wfail_in;
   logic                 repeat_ff, repeat_in;
   logic                 wempty_ff, wempty_in;
   logic                 drop_ff, drop_in;
   logic [QFILL_W-1:0]   qfill_ff, qfill_in;
   logic [FILL_W+QFILL_W-1:0] fill_wide;

   // decode of the held item
   logic                 is_push;
   logic                 active;
   logic                 ring_empty;
   logic [TIME_W-1:0]    dl_eff;
   logic                 emit;
   logic                 late;
   logic [SEQ_BITS-1:0]  head;
   logic [SEQ_BITS+OSEQ_W-1:0] head_wide;
   logic [PTR_W-1:0]     wr_inc, rd_inc;

   // remainder unit
   logic [TIME_W-1:0]    span;
   logic                 rem_done;
   logic [PERIOD_W-1:0]  rem;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pace_ff   <= 1'b0;
         period_ff <= PERIOD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_PACE_ENABLE: pace_ff   <= csr_wdata[0];
            REG_PERIOD_NS:   period_ff <= csr_wdata;
            default: begin
               pace_ff <= pace_ff;
            end
         endcase
      end
   end

   // treat a zero period as one
   assign period_eff = (period_ff == '0) ? PERIOD_W'(1) : period_ff;

   // capture the request item, sequence masked to the stored width
   assign seq_wide = {{SEQ_BITS{1'b0}}, req_frame_num};

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_cmd_ff  <= req_command;
         item_seq_ff  <= seq_wide[SEQ_BITS-1:0];
         item_now_ff  <= req_now_ns;
         item_sink_ff <= req_sink_open;
         item_wok_ff  <= req_write_ok;
         item_done_ff <= req_done_ns;
      end
   end

   // decode the held item against the queue state
   always_comb begin
      is_push    = item_cmd_ff == CMD_PUSH;
      active     = !is_push && pace_ff && item_sink_ff;
      ring_empty = fill_ff == '0;
      dl_eff     = (deadline_ff == '0) ? item_now_ff : deadline_ff;
      emit       = active && !ring_empty && (item_now_ff >= dl_eff);
      late       = dl_eff <= item_done_ff;
      head       = ring_ff[rd_ff];
      head_wide  = {{OSEQ_W{1'b0}}, head};
      wr_inc     = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      rd_inc     = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      span       = item_done_ff - dl_eff;
   end

   // execute the item: next queue state and result fields
   always_comb begin
      wr_in       = wr_ff;
      rd_in       = rd_ff;
      fill_in     = fill_ff;
      deadline_in = deadline_ff;
      shown_in    = shown_ff;
      last_in     = last_ff;
      emitted_in  = 1'b0;
      eseq_in     = '0;
      wfail_in    = 1'b0;
      repeat_in   = 1'b0;
      wempty_in   = 1'b0;
      drop_in     = 1'b0;
      if (cmd.exec) begin
         if (is_push) begin
            // drop the oldest entry of a full ring, then append
            wr_in = wr_inc;
            if (fill_ff == FILL_FULL) begin
               drop_in = 1'b1;
               rd_in   = rd_inc;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end else if (active) begin
            if (ring_empty) begin
               wempty_in = shown_ff;
            end else begin
               deadline_in = dl_eff;
               if (emit) begin
                  emitted_in = 1'b1;
                  eseq_in    = head_wide[OSEQ_W-1:0];
                  if (item_wok_ff) begin
                     repeat_in = head == last_ff;
                     last_in   = head;
                     shown_in  = 1'b1;
                     rd_in     = rd_inc;
                     fill_in   = fill_ff - 1'b1;
                  end else begin
                     wfail_in = 1'b1;
                  end
                  // deadline ahead of the write: one period suffices
                  if (!late) begin
                     deadline_in = dl_eff + {{(TIME_W-PERIOD_W){1'b0}}, period_eff};
                  end
               end
            end
         end
      end else if (cmd.fin) begin
         // first period boundary past the write-done time
         deadline_in = item_done_ff - {{(TIME_W-PERIOD_W){1'b0}}, rem}
                       + {{(TIME_W-PERIOD_W){1'b0}}, period_eff};
      end
   end

   assign fill_wide = {{QFILL_W{1'b0}}, fill_in};
   assign qfill_in  = fill_wide[QFILL_W-1:0];

   // ring write on a push
   always_ff @(posedge clock) begin
      if (cmd.exec && is_push) begin
         ring_ff[wr_ff] <= item_seq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff       <= '0;
         rd_ff       <= '0;
         fill_ff     <= '0;
         deadline_ff <= '0;
         shown_ff    <= 1'b0;
         last_ff     <= '0;
      end else begin
         wr_ff       <= wr_in;
         rd_ff       <= rd_in;
         fill_ff     <= fill_in;
         deadline_ff <= deadline_in;
         shown_ff    <= shown_in;
         last_ff     <= last_in;
      end
   end

   // result register: load on execute, release on transfer
   assign rsp_valid_in = cmd.exec ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         emitted_ff <= emitted_in;
         eseq_ff    <= eseq_in;
         wfail_ff   <= wfail_in;
         repeat_ff  <= repeat_in;
         wempty_ff  <= wempty_in;
         drop_ff    <= drop_in;
         qfill_ff   <= qfill_in;
      end
   end

   fpq_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (span),
      .divisor   (period_eff),
      .done      (rem_done),
      .remainder (rem)
   );

   // status to the controller
   always_comb begin
      sts.out_free = !rsp_valid_ff || !rsp_stall;
      sts.need_div = emit && late;
      sts.div_done = rem_done;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_emitted        = emitted_ff;
   assign rsp_emitted_seq    = eseq_ff;
   assign rsp_write_failed   = wfail_ff;
   assign rsp_repeat_of_last = repeat_ff;
   assign rsp_waiting_empty  = wempty_ff;
   assign rsp_dropped_oldest = drop_ff;
   assign rsp_queue_fill     = qfill_ff;

   // the ring never holds more than its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("fill count beyond ring depth");

   // a failed write leaves the fill count where it was
   a_fail_keeps: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && emit && !item_wok_ff |=> fill_ff == $past(fill_ff))
      else $error("failed write changed the fill count");

   // an emission and an empty-ring report never share a result
   a_emit_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(emitted_ff && wempty_ff))
      else $error("result reports both an emission and an empty ring");

   // the deadline moves past its old value after an emission ahead of the write
   a_deadline_set: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && emit && !late |=> deadline_ff != $past(dl_eff) || $past(period_eff) == '0)
      else $error("deadline did not advance after an emission");

endmodule
`default_nettype wire

// File: rtl/frame_pacing_queue_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// frame_pacing_queue_top: paced output of queued frame sequence numbers
// Pushes append to a small ring, dropping the oldest on overflow; ticks send
// the oldest entry once the pacing deadline is reached and advance the
// deadline by whole periods past the write-done time.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    command, frame_num, now_ns, ...
//   rsp      out        rsp_valid/stall    emitted, emitted_seq, ... fill
//   csr      in         csr_write_en       csr_index, csr_wdata
//
// A push or a tick without catch-up is accepted, then executed.
// An emitting tick whose deadline is at or before the write-done time adds
// 64 remainder steps, one dividend bit each, then the deadline write.
// Reset is synchronous and clears control state; the ring needs no clearing.
// The next item is accepted while a result waits in the output register;
// it executes as soon as that register is free.
// ---------------------------------------------------------------------------
module frame_pacing_queue_top #(
   parameter int RING_DEPTH = 4,
   parameter int SEQ_BITS   = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [fpq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fpq_pkg::PERIOD_W-1:0]      csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_command,
   input  wire logic [fpq_pkg::OSEQ_W-1:0]        req_frame_num,
   input  wire logic [fpq_pkg::TIME_W-1:0]        req_now_ns,
   input  wire logic                              req_sink_open,
   input  wire logic                              req_write_ok,
   input  wire logic [fpq_pkg::TIME_W-1:0]        req_done_ns,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_emitted,
   output logic [fpq_pkg::OSEQ_W-1:0]             rsp_emitted_seq,
   output logic                                   rsp_write_failed,
   output logic                                   rsp_repeat_of_last,
   output logic                                   rsp_waiting_empty,
   output logic                                   rsp_dropped_oldest,
   output logic [fpq_pkg::QFILL_W-1:0]            rsp_queue_fill
);
   import fpq_pkg::*;

   fpq_cmd_type cmd;
   fpq_sts_type sts;

   fpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fpq_datapath #(
      .RING_DEPTH (RING_DEPTH),
      .SEQ_BITS   (SEQ_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_command        (req_command),
      .req_frame_num      (req_frame_num),
      .req_now_ns         (req_now_ns),
      .req_sink_open      (req_sink_open),
      .req_write_ok       (req_write_ok),
      .req_done_ns        (req_done_ns),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_emitted        (rsp_emitted),
      .rsp_emitted_seq    (rsp_emitted_seq),
      .rsp_write_failed   (rsp_write_failed),
      .rsp_repeat_of_last (rsp_repeat_of_last),
      .rsp_waiting_empty  (rsp_waiting_empty),
      .rsp_dropped_oldest (rsp_dropped_oldest),
      .rsp_queue_fill     (rsp_queue_fill)
   );

endmodule
`default_nettype wire
